/* src/sbdma_pkg.sv */
// ============================================================================
// sbdma_pkg
// Shared types, constants and helpers for the strided block DMA address
// generator.
// ============================================================================
package sbdma_pkg;

    // Default configuration of the generator.
    localparam int LOCAL_MEM_BYTES = 4096;
    localparam int RAM_ADDR_BITS   = 24;

    // Reset value of the RAM size register.
    localparam logic [24:0] RAM_SIZE_RESET = 25'd4194304;

    // Input opcodes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Decoded start parameters, held in the input register.
    typedef struct packed {
        logic [23:0] raddr;       // aligned, masked RAM start address
        logic [11:0] laddr;       // aligned, wrapped local start address
        logic        imem;        // instruction memory select
        logic [8:0]  beats_m1;    // beats per row minus one
        logic [7:0]  rows_m1;     // row count minus one
        logic [11:0] skip;        // RAM bytes skipped after each row
        logic [22:0] extent;      // (row length + skip) times row count
    } t_start_info;

    // Reduce an address modulo the local memory size, then align to 8 bytes.
    // The input never reaches five times the memory size, so four
    // compare-and-subtract steps are enough.
    function automatic logic [11:0] local_wrap(input logic [12:0] a,
                                               input logic [12:0] mem_bytes);
        logic [12:0] v;
        v = a;
        for (int k = 0; k < 4; k++) begin
            if (v >= mem_bytes) begin
                v = v - mem_bytes;
            end
        end
        return v[11:0] & 12'hFF8;
    endfunction

endpackage

/* src/sbdma_start_decode.sv */
// ============================================================================
// sbdma_start_decode
// Decodes the register fields of a start transaction: address alignment,
// local wrap, row geometry and the RAM extent used by the bound check.
// ============================================================================
module sbdma_start_decode #(
    parameter int LOCAL_MEM_BYTES = sbdma_pkg::LOCAL_MEM_BYTES,
    parameter int RAM_ADDR_BITS   = sbdma_pkg::RAM_ADDR_BITS
) (
    input  logic [12:0]              i_local_addr_reg,
    input  logic [23:0]              i_ram_addr_reg,
    input  logic [31:0]              i_length_word,
    output sbdma_pkg::t_start_info   o_info
);

    localparam logic [23:0] RamMask = 24'((25'd1 << RAM_ADDR_BITS) - 25'd1);

    logic [12:0] row_len;
    logic [13:0] row_stride;
    logic [8:0]  row_count;

    // Row length rounded up to 8 bytes, row count, and RAM stride per row.
    assign row_len    = 13'(i_length_word[11:0] | 12'd7) + 13'd1;
    assign row_count  = {1'b0, i_length_word[19:12]} + 9'd1;
    assign row_stride = {1'b0, row_len} + {2'b00, i_length_word[31:20]};

    // Assemble the decoded start parameters.
    always_comb begin
        o_info.raddr    = i_ram_addr_reg & RamMask & 24'hFFFFF8;
        o_info.laddr    = sbdma_pkg::local_wrap({1'b0, i_local_addr_reg[11:0]},
                                                13'(LOCAL_MEM_BYTES));
        o_info.imem     = i_local_addr_reg[12];
        o_info.beats_m1 = i_length_word[11:3];
        o_info.rows_m1  = i_length_word[19:12];
        o_info.skip     = i_length_word[31:20];
        o_info.extent   = 23'(row_stride * row_count);
    end

endmodule

/* src/strided_block_dma_address_gen.sv */
// ============================================================================
// strided_block_dma_address_gen
// Strided 2-D DMA address generator: a start transaction latches a checked
// transfer, each tick during a transfer issues one 8-byte beat address pair.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  in        i_in_valid / o_in_ready + item fields     into block
//  out       o_out_valid / i_out_ready + result fields out of block
//  cfg       i_cfg_valid / o_cfg_ready + i_cfg_data    into block
//
// One transaction is accepted per cycle while o_in_ready is high; it waits in
// the input register, moves on to the result register and is offered on the
// outputs from there. Decode runs ahead of the input register, update after it.
// Synchronous active-low reset clears the transfer state and the valid flags of
// both stages, and loads the RAM size register with 4 MB.
// When the result is not taken, the result register holds, the input
// register fills, and o_in_ready drops until the output side moves.
// The cfg channel is always ready and writes the RAM size register.
module strided_block_dma_address_gen #(
    parameter int LOCAL_MEM_BYTES = sbdma_pkg::LOCAL_MEM_BYTES,
    parameter int RAM_ADDR_BITS   = sbdma_pkg::RAM_ADDR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [24:0] i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic        i_to_ram,
    input  logic [12:0] i_local_addr_reg,
    input  logic [23:0] i_ram_addr_reg,
    input  logic [31:0] i_length_word,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_beat_valid,
    output logic [23:0] o_ram_beat_addr,
    output logic [11:0] o_local_beat_addr,
    output logic        o_imem_select,
    output logic        o_toward_ram,
    output logic        o_last_beat,
    output logic        o_overflow,
    output logic        o_busy_res
);

    localparam logic [23:0] RamMask = 24'((25'd1 << RAM_ADDR_BITS) - 25'd1);

    // Configuration register.
    logic [24:0] r_ram_size;

    // Input stage.
    logic                   r_in_valid;
    logic                   r_in_opcode;
    logic                   r_in_to_ram;
    sbdma_pkg::t_start_info r_in_info;
    sbdma_pkg::t_start_info dec_info;

    // Transfer state.
    logic        r_active,        n_active;
    logic        r_dir,           n_dir;
    logic        r_imem,          n_imem;
    logic [23:0] r_ram_pointer,   n_ram_pointer;
    logic [11:0] r_local_pointer, n_local_pointer;
    logic [8:0]  r_beat_in_row,   n_beat_in_row;
    logic [8:0]  r_beats_m1,      n_beats_m1;
    logic [7:0]  r_rows_left,     n_rows_left;
    logic [11:0] r_skip,          n_skip;

    // Result register.
    logic        r_out_valid;
    logic        r_beat_valid,  n_beat_valid;
    logic [23:0] r_ram_beat,    n_ram_beat;
    logic [11:0] r_local_beat,  n_local_beat;
    logic        r_imem_sel,    n_imem_sel;
    logic        r_toward,      n_toward;
    logic        r_last,        n_last;
    logic        r_overflow,    n_overflow;
    logic        r_busy,        n_busy;

    logic        in_load;
    logic        advance;
    logic [24:0] end_addr;
    logic        row_end;
    logic        last;

    // Handshake between the input stage and the result register.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_load     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Start field decode ahead of the input register.
    sbdma_start_decode #(
        .LOCAL_MEM_BYTES (LOCAL_MEM_BYTES),
        .RAM_ADDR_BITS   (RAM_ADDR_BITS)
    ) u_decode (
        .i_local_addr_reg (i_local_addr_reg),
        .i_ram_addr_reg   (i_ram_addr_reg),
        .i_length_word    (i_length_word),
        .o_info           (dec_info)
    );

    // Configuration register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_size <= sbdma_pkg::RAM_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ram_size <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_opcode <= i_opcode;
            r_in_to_ram <= i_to_ram;
            r_in_info   <= dec_info;
        end
    end

    // End of the RAM extent and the row/transfer end flags.
    assign end_addr = {1'b0, r_in_info.raddr} + {2'b00, r_in_info.extent};
    assign row_end  = (r_beat_in_row == r_beats_m1);
    assign last     = row_end && (r_rows_left == 8'd0);

    // Per-transaction update of the transfer state and the result.
    always_comb begin
        n_active        = r_active;
        n_dir           = r_dir;
        n_imem          = r_imem;
        n_ram_pointer   = r_ram_pointer;
        n_local_pointer = r_local_pointer;
        n_beat_in_row   = r_beat_in_row;
        n_beats_m1      = r_beats_m1;
        n_rows_left     = r_rows_left;
        n_skip          = r_skip;

        n_beat_valid = 1'b0;
        n_ram_beat   = 24'd0;
        n_local_beat = 12'd0;
        n_imem_sel   = 1'b0;
        n_toward     = 1'b0;
        n_last       = 1'b0;
        n_overflow   = 1'b0;
        n_busy       = 1'b0;

        case (r_in_opcode)
            sbdma_pkg::OP_START: begin
                if (end_addr > r_ram_size) begin
                    n_active   = 1'b0;
                    n_overflow = 1'b1;
                end else begin
                    n_active        = 1'b1;
                    n_dir           = r_in_to_ram;
                    n_imem          = r_in_info.imem;
                    n_ram_pointer   = r_in_info.raddr;
                    n_local_pointer = r_in_info.laddr;
                    n_beat_in_row   = 9'd0;
                    n_beats_m1      = r_in_info.beats_m1;
                    n_rows_left     = r_in_info.rows_m1;
                    n_skip          = r_in_info.skip;
                    n_busy          = 1'b1;
                end
            end
            sbdma_pkg::OP_TICK: begin
                if (r_active) begin
                    n_beat_valid = 1'b1;
                    n_ram_beat   = r_ram_pointer;
                    n_local_beat = r_local_pointer;
                    n_imem_sel   = r_imem;
                    n_toward     = r_dir;
                    n_last       = last;

                    n_local_pointer = sbdma_pkg::local_wrap(
                        {1'b0, r_local_pointer} + 13'd8, 13'(LOCAL_MEM_BYTES));
                    if (row_end) begin
                        n_ram_pointer = (r_ram_pointer + 24'd8 + {12'd0, r_skip})
                                        & RamMask;
                        n_beat_in_row = 9'd0;
                        n_rows_left   = r_rows_left - 8'd1;
                    end else begin
                        n_ram_pointer = (r_ram_pointer + 24'd8) & RamMask;
                        n_beat_in_row = r_beat_in_row + 9'd1;
                    end
                    n_active = !last;
                    n_busy   = !last;
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    // Transfer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= 1'b0;
            r_dir           <= 1'b0;
            r_imem          <= 1'b0;
            r_ram_pointer   <= 24'd0;
            r_local_pointer <= 12'd0;
            r_beat_in_row   <= 9'd0;
            r_beats_m1      <= 9'd0;
            r_rows_left     <= 8'd0;
            r_skip          <= 12'd0;
        end else if (advance) begin
            r_active        <= n_active;
            r_dir           <= n_dir;
            r_imem          <= n_imem;
            r_ram_pointer   <= n_ram_pointer;
            r_local_pointer <= n_local_pointer;
            r_beat_in_row   <= n_beat_in_row;
            r_beats_m1      <= n_beats_m1;
            r_rows_left     <= n_rows_left;
            r_skip          <= n_skip;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_beat_valid <= n_beat_valid;
            r_ram_beat   <= n_ram_beat;
            r_local_beat <= n_local_beat;
            r_imem_sel   <= n_imem_sel;
            r_toward     <= n_toward;
            r_last       <= n_last;
            r_overflow   <= n_overflow;
            r_busy       <= n_busy;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_beat_valid      = r_beat_valid;
    assign o_ram_beat_addr   = r_ram_beat;
    assign o_local_beat_addr = r_local_beat;
    assign o_imem_select     = r_imem_sel;
    assign o_toward_ram      = r_toward;
    assign o_last_beat       = r_last;
    assign o_overflow        = r_overflow;
    assign o_busy_res        = r_busy;

endmodule

/* src/sbdma_checker.sv */
// ============================================================================
// sbdma_checker
// Port-level assertions for the strided block DMA address generator, bound
// to the top level.
// ============================================================================
module sbdma_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_beat_valid,
    input  logic [11:0] o_local_beat_addr,
    input  logic        o_last_beat,
    input  logic        o_overflow,
    input  logic        o_busy_res
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // A rejected start never carries a beat and leaves the block idle.
    a_overflow_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> !o_beat_valid && !o_busy_res)
        else $error("overflow result with a beat or busy set");

    // The final beat is a real beat and ends the transfer.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_beat |-> o_beat_valid && !o_busy_res)
        else $error("last beat without beat or with busy still set");

    // Local beat addresses are 8-byte aligned. The RAM address is not, since
    // the row skip may be any byte count.
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beat_valid |-> (o_local_beat_addr[2:0] == 3'd0))
        else $error("local beat address not 8-byte aligned");

    // A beat that is not the last one leaves the transfer running.
    a_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beat_valid && !o_last_beat |-> o_busy_res)
        else $error("transfer stopped before its last beat");

endmodule

bind strided_block_dma_address_gen sbdma_checker u_sbdma_checker (.*);
